[rtl/lwmr_pkg.sv]
// Shared constants, types and helper functions of the wave maze router.
`timescale 1ns / 1ps
package lwmr_pkg;

    localparam int GRID_ROWS = 8;
    localparam int GRID_COLS = 8;
    localparam int CELLS     = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int ROW_W     = 3;
    localparam int COL_W     = 3;
    localparam int LABEL_W   = 7;

    localparam logic [LABEL_W-1:0] UNLABELED = {LABEL_W{1'b1}};

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    localparam logic [1:0] DIR_ROW_UP   = 2'd0;
    localparam logic [1:0] DIR_ROW_DOWN = 2'd1;
    localparam logic [1:0] DIR_COL_UP   = 2'd2;
    localparam logic [1:0] DIR_COL_DOWN = 2'd3;

    typedef enum logic [1:0] {
        RD_CUR,
        RD_NB,
        RD_START,
        RD_FIN
    } rd_sel_t;

    typedef enum logic [1:0] {
        WS_CUR_UNLAB,
        WS_START_ZERO,
        WS_NB_NEXT,
        WS_FIN_NEXT
    } wr_sel_t;

    typedef struct packed {
        logic    take;
        logic    cur_clr;
        logic    cur_inc;
        logic    cur_to_nb;
        logic    cur_to_fin;
        logic    dir_clr;
        logic    dir_inc;
        logic    dist_clr;
        logic    dist_inc;
        logic    grown_clr;
        logic    grown_set;
        logic    lab_load;
        logic    lab_dec;
        logic    wall_clr;
        logic    lbl_we;
        wr_sel_t lbl_wsel;
        rd_sel_t rd_sel;
        logic    out_load;
        logic    out_fail;
    } lwmr_cmd_t;

    typedef struct packed {
        logic in_cmd;
        logic scan_last;
        logic dir_last;
        logic nb_in_grid;
        logic nb_is_fin;
        logic lbl_eq_dist;
        logic lbl_eq_prev;
        logic nb_free;
        logic wall_hit;
        logic lab_zero;
        logic out_busy;
        logic solve_bad;
    } lwmr_status_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        int idx;
        idx = int'(r) * GRID_COLS + int'(c);
        return idx[ADDR_W-1:0];
    endfunction

    function automatic logic in_grid(input logic [ROW_W-1:0] r,
                                     input logic [COL_W-1:0] c);
        return (int'(r) < GRID_ROWS) && (int'(c) < GRID_COLS);
    endfunction

endpackage

[rtl/lwmr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module lwmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/lwmr_datapath.sv]
// Datapath of the router: position and level registers, wall and label memories, result register.
`timescale 1ns / 1ps
module lwmr_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lwmr_pkg::lwmr_cmd_t           cmd,
    output lwmr_pkg::lwmr_status_t        status,
    output logic                          grown_out,
    input  logic                          in_command,
    input  logic [lwmr_pkg::ROW_W-1:0]    in_row,
    input  logic [lwmr_pkg::COL_W-1:0]    in_col,
    input  logic                          in_wall,
    input  logic [lwmr_pkg::ROW_W-1:0]    in_target_row,
    input  logic [lwmr_pkg::COL_W-1:0]    in_target_col,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lwmr_pkg::ROW_W-1:0]    out_path_row,
    output logic [lwmr_pkg::COL_W-1:0]    out_path_col,
    output logic                          out_found,
    output logic                          out_last
);

    localparam logic [lwmr_pkg::ROW_W-1:0] ROW_MAX = lwmr_pkg::ROW_W'(lwmr_pkg::GRID_ROWS - 1);
    localparam logic [lwmr_pkg::COL_W-1:0] COL_MAX = lwmr_pkg::COL_W'(lwmr_pkg::GRID_COLS - 1);

    logic [lwmr_pkg::ROW_W-1:0]   sr_reg;
    logic [lwmr_pkg::COL_W-1:0]   sc_reg;
    logic [lwmr_pkg::ROW_W-1:0]   fr_reg;
    logic [lwmr_pkg::COL_W-1:0]   fc_reg;
    logic [lwmr_pkg::ROW_W-1:0]   cur_r_reg;
    logic [lwmr_pkg::COL_W-1:0]   cur_c_reg;
    logic [1:0]                   dir_reg;
    logic [lwmr_pkg::LABEL_W-1:0] dist_reg, lab_reg;
    logic                         grown_reg;
    logic                         out_valid_reg, out_found_reg, out_last_reg;
    logic [lwmr_pkg::ROW_W-1:0]   out_row_reg;
    logic [lwmr_pkg::COL_W-1:0]   out_col_reg;

    logic [lwmr_pkg::ROW_W-1:0]   nb_r;
    logic [lwmr_pkg::COL_W-1:0]   nb_c;
    logic                         nb_ok;
    logic [lwmr_pkg::ADDR_W-1:0]  cur_addr, nb_addr, start_addr, fin_addr, rd_addr;
    logic [lwmr_pkg::ADDR_W-1:0]  lbl_waddr, wall_waddr;
    logic [lwmr_pkg::LABEL_W-1:0] lbl_wdata, lbl_rdata;
    logic                         wall_we, wall_wdata, wall_rdata;

    always_comb begin
        nb_r  = cur_r_reg;
        nb_c  = cur_c_reg;
        nb_ok = 1'b0;
        case (dir_reg)
            lwmr_pkg::DIR_ROW_UP: begin
                nb_r  = cur_r_reg + 1'b1;
                nb_ok = (cur_r_reg != ROW_MAX);
            end
            lwmr_pkg::DIR_ROW_DOWN: begin
                nb_r  = cur_r_reg - 1'b1;
                nb_ok = (cur_r_reg != '0);
            end
            lwmr_pkg::DIR_COL_UP: begin
                nb_c  = cur_c_reg + 1'b1;
                nb_ok = (cur_c_reg != COL_MAX);
            end
            lwmr_pkg::DIR_COL_DOWN: begin
                nb_c  = cur_c_reg - 1'b1;
                nb_ok = (cur_c_reg != '0);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    assign cur_addr   = lwmr_pkg::cell_addr(cur_r_reg, cur_c_reg);
    assign nb_addr    = lwmr_pkg::cell_addr(nb_r, nb_c);
    assign start_addr = lwmr_pkg::cell_addr(sr_reg, sc_reg);
    assign fin_addr   = lwmr_pkg::cell_addr(fr_reg, fc_reg);

    always_comb begin
        case (cmd.rd_sel)
            lwmr_pkg::RD_CUR:   rd_addr = cur_addr;
            lwmr_pkg::RD_NB:    rd_addr = nb_addr;
            lwmr_pkg::RD_START: rd_addr = start_addr;
            lwmr_pkg::RD_FIN:   rd_addr = fin_addr;
            default:            rd_addr = cur_addr;
        endcase
    end

    always_comb begin
        case (cmd.lbl_wsel)
            lwmr_pkg::WS_CUR_UNLAB: begin
                lbl_waddr = cur_addr;
                lbl_wdata = lwmr_pkg::UNLABELED;
            end
            lwmr_pkg::WS_START_ZERO: begin
                lbl_waddr = start_addr;
                lbl_wdata = '0;
            end
            lwmr_pkg::WS_NB_NEXT: begin
                lbl_waddr = nb_addr;
                lbl_wdata = dist_reg + 1'b1;
            end
            lwmr_pkg::WS_FIN_NEXT: begin
                lbl_waddr = fin_addr;
                lbl_wdata = dist_reg + 1'b1;
            end
            default: begin
                lbl_waddr = cur_addr;
                lbl_wdata = lwmr_pkg::UNLABELED;
            end
        endcase
    end

    // A map write from the input stream lands on the transfer itself.
    always_comb begin
        wall_we    = 1'b0;
        wall_waddr = cur_addr;
        wall_wdata = 1'b0;
        if (cmd.wall_clr) begin
            wall_we = 1'b1;
        end else if (cmd.take && (in_command == lwmr_pkg::CMD_WRITE)
                     && lwmr_pkg::in_grid(in_row, in_col)) begin
            wall_we    = 1'b1;
            wall_waddr = lwmr_pkg::cell_addr(in_row, in_col);
            wall_wdata = in_wall;
        end
    end

    lwmr_ram #(.WIDTH(1), .DEPTH(lwmr_pkg::CELLS)) u_wall_ram (
        .aclk  (aclk),
        .we    (wall_we),
        .waddr (wall_waddr),
        .wdata (wall_wdata),
        .raddr (rd_addr),
        .rdata (wall_rdata)
    );

    lwmr_ram #(.WIDTH(lwmr_pkg::LABEL_W), .DEPTH(lwmr_pkg::CELLS)) u_label_ram (
        .aclk  (aclk),
        .we    (cmd.lbl_we),
        .waddr (lbl_waddr),
        .wdata (lbl_wdata),
        .raddr (rd_addr),
        .rdata (lbl_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_r_reg     <= '0;
            cur_c_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.cur_clr) begin
                cur_r_reg <= '0;
                cur_c_reg <= '0;
            end else if (cmd.cur_inc) begin
                if (cur_c_reg == COL_MAX) begin
                    cur_c_reg <= '0;
                    cur_r_reg <= cur_r_reg + 1'b1;
                end else begin
                    cur_c_reg <= cur_c_reg + 1'b1;
                end
            end else if (cmd.cur_to_nb) begin
                cur_r_reg <= nb_r;
                cur_c_reg <= nb_c;
            end else if (cmd.cur_to_fin) begin
                cur_r_reg <= fr_reg;
                cur_c_reg <= fc_reg;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            sr_reg <= in_row;
            sc_reg <= in_col;
            fr_reg <= in_target_row;
            fc_reg <= in_target_col;
        end
        if (cmd.dir_clr) begin
            dir_reg <= lwmr_pkg::DIR_ROW_UP;
        end else if (cmd.dir_inc) begin
            dir_reg <= dir_reg + 1'b1;
        end
        if (cmd.dist_clr) begin
            dist_reg <= '0;
        end else if (cmd.dist_inc) begin
            dist_reg <= dist_reg + 1'b1;
        end
        if (cmd.grown_clr) begin
            grown_reg <= 1'b0;
        end else if (cmd.grown_set) begin
            grown_reg <= 1'b1;
        end
        if (cmd.lab_load) begin
            lab_reg <= dist_reg + 1'b1;
        end else if (cmd.lab_dec) begin
            lab_reg <= lab_reg - 1'b1;
        end
        if (cmd.out_load) begin
            if (cmd.out_fail) begin
                out_row_reg   <= '0;
                out_col_reg   <= '0;
                out_found_reg <= 1'b0;
                out_last_reg  <= 1'b1;
            end else begin
                out_row_reg   <= cur_r_reg;
                out_col_reg   <= cur_c_reg;
                out_found_reg <= 1'b1;
                out_last_reg  <= (lab_reg == '0);
            end
        end
    end

    always_comb begin
        status.in_cmd      = in_command;
        status.scan_last   = (cur_r_reg == ROW_MAX) && (cur_c_reg == COL_MAX);
        status.dir_last    = (dir_reg == lwmr_pkg::DIR_COL_DOWN);
        status.nb_in_grid  = nb_ok;
        status.nb_is_fin   = (nb_addr == fin_addr);
        status.lbl_eq_dist = (lbl_rdata == dist_reg);
        status.lbl_eq_prev = (lbl_rdata == lab_reg - 1'b1);
        status.nb_free     = !wall_rdata && (lbl_rdata == lwmr_pkg::UNLABELED);
        status.wall_hit    = wall_rdata;
        status.lab_zero    = (lab_reg == '0);
        status.out_busy    = out_valid_reg && !out_ready;
        status.solve_bad   = !lwmr_pkg::in_grid(sr_reg, sc_reg)
                             || !lwmr_pkg::in_grid(fr_reg, fc_reg)
                             || (start_addr == fin_addr);
    end

    assign out_valid    = out_valid_reg;
    assign out_path_row = out_row_reg;
    assign out_path_col = out_col_reg;
    assign out_found    = out_found_reg;
    assign out_last     = out_last_reg;

    assign grown_out = grown_reg;

endmodule

[rtl/lwmr_ctrl.sv]
// Sequencer of the router: map clearing, wave spreading and traceback control.
`timescale 1ns / 1ps
module lwmr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   grown,
    input  lwmr_pkg::lwmr_status_t status,
    output lwmr_pkg::lwmr_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_WCLR,
        S_IDLE,
        S_LCLR,
        S_PRE,
        S_PRE_S,
        S_PRE_F,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_NEXT,
        S_NB_RD,
        S_NB_CHK,
        S_TB_EMIT,
        S_TB_RD,
        S_TB_CHK,
        S_FAIL
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel   = lwmr_pkg::RD_CUR;
        cmd.lbl_wsel = lwmr_pkg::WS_CUR_UNLAB;
        in_ready   = 1'b0;
        case (state_reg)
            S_WCLR: begin
                cmd.wall_clr = 1'b1;
                cmd.cur_inc  = 1'b1;
                if (status.scan_last) begin
                    cmd.cur_inc = 1'b0;
                    cmd.cur_clr = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.take    = 1'b1;
                    cmd.cur_clr = 1'b1;
                    if (status.in_cmd == lwmr_pkg::CMD_SOLVE) begin
                        state_next = S_LCLR;
                    end
                end
            end
            S_LCLR: begin
                cmd.lbl_we   = 1'b1;
                cmd.lbl_wsel = lwmr_pkg::WS_CUR_UNLAB;
                cmd.cur_inc  = 1'b1;
                if (status.scan_last) begin
                    state_next = S_PRE;
                end
            end
            S_PRE: begin
                cmd.rd_sel = lwmr_pkg::RD_START;
                state_next = status.solve_bad ? S_FAIL : S_PRE_S;
            end
            S_PRE_S: begin
                cmd.rd_sel = lwmr_pkg::RD_FIN;
                state_next = status.wall_hit ? S_FAIL : S_PRE_F;
            end
            S_PRE_F: begin
                if (status.wall_hit) begin
                    state_next = S_FAIL;
                end else begin
                    cmd.lbl_we    = 1'b1;
                    cmd.lbl_wsel  = lwmr_pkg::WS_START_ZERO;
                    cmd.dist_clr  = 1'b1;
                    cmd.grown_clr = 1'b1;
                    cmd.cur_clr   = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                cmd.rd_sel = lwmr_pkg::RD_CUR;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (status.lbl_eq_dist) begin
                    cmd.dir_clr = 1'b1;
                    state_next  = S_NB_RD;
                end else begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                if (status.scan_last) begin
                    if (grown) begin
                        cmd.dist_inc  = 1'b1;
                        cmd.grown_clr = 1'b1;
                        cmd.cur_clr   = 1'b1;
                        state_next    = S_SCAN_RD;
                    end else begin
                        state_next = S_FAIL;
                    end
                end else begin
                    cmd.cur_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_NB_RD: begin
                cmd.rd_sel = lwmr_pkg::RD_NB;
                if (!status.nb_in_grid) begin
                    if (status.dir_last) begin
                        state_next = S_NEXT;
                    end else begin
                        cmd.dir_inc = 1'b1;
                    end
                end else if (status.nb_is_fin) begin
                    cmd.lbl_we     = 1'b1;
                    cmd.lbl_wsel   = lwmr_pkg::WS_FIN_NEXT;
                    cmd.lab_load   = 1'b1;
                    cmd.cur_to_fin = 1'b1;
                    state_next     = S_TB_EMIT;
                end else begin
                    state_next = S_NB_CHK;
                end
            end
            S_NB_CHK: begin
                if (status.nb_free) begin
                    cmd.lbl_we    = 1'b1;
                    cmd.lbl_wsel  = lwmr_pkg::WS_NB_NEXT;
                    cmd.grown_set = 1'b1;
                end
                if (status.dir_last) begin
                    state_next = S_NEXT;
                end else begin
                    cmd.dir_inc = 1'b1;
                    state_next  = S_NB_RD;
                end
            end
            S_TB_EMIT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    cmd.dir_clr  = 1'b1;
                    state_next   = status.lab_zero ? S_IDLE : S_TB_RD;
                end
            end
            S_TB_RD: begin
                cmd.rd_sel = lwmr_pkg::RD_NB;
                if (status.nb_in_grid) begin
                    state_next = S_TB_CHK;
                end else begin
                    cmd.dir_inc = 1'b1;
                end
            end
            S_TB_CHK: begin
                if (status.lbl_eq_prev) begin
                    cmd.cur_to_nb = 1'b1;
                    cmd.lab_dec   = 1'b1;
                    state_next    = S_TB_EMIT;
                end else begin
                    cmd.dir_inc = 1'b1;
                    state_next  = S_TB_RD;
                end
            end
            S_FAIL: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    cmd.out_fail = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_WCLR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/lee_wave_maze_router_unit.sv]
// Top level of the Lee wave maze router: stream ports, sequencer and datapath.
//
//  Channel  | Direction | Payload                                  | Marker
//  s_axis   | in        | command, row, col, wall, target_row/col  | none
//  m_axis   | out       | path_row, path_col, found                | tlast = last
//
// After reset the wall map is swept free cell by cell, with s_tready low.
// A map write is done on its transfer. A solve clears the labels, then scans
// all 64 cells once per wave level, reading each cell and its neighbours in turn
// through the single label memory read port, then traces back one path cell at a time.
// One item is worked at a time; a stalled m_tready holds the sequencer at its
// next result while the result register keeps its transfer pending.
`timescale 1ns / 1ps
module lee_wave_maze_router_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[0], row[3:1], col[6:4], wall[7], target_row[10:8], target_col[13:11]
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // path_row[2:0], path_col[5:3], found[6]
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    lwmr_pkg::lwmr_cmd_t    cmd;
    lwmr_pkg::lwmr_status_t status;
    logic [lwmr_pkg::ROW_W-1:0] path_row;
    logic [lwmr_pkg::COL_W-1:0] path_col;
    logic                       found;
    logic                       u_dp_grown;

    lwmr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .grown    (u_dp_grown),
        .status   (status),
        .cmd      (cmd)
    );

    lwmr_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .grown_out     (u_dp_grown),
        .in_command    (s_tdata[0]),
        .in_row        (s_tdata[3:1]),
        .in_col        (s_tdata[6:4]),
        .in_wall       (s_tdata[7]),
        .in_target_row (s_tdata[10:8]),
        .in_target_col (s_tdata[13:11]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_path_row  (path_row),
        .out_path_col  (path_col),
        .out_found     (found),
        .out_last      (m_tlast)
    );

    assign m_tdata = {1'b0, found, path_col, path_row};

endmodule

[tb/tb_lee_wave_maze_router_unit.sv]
// Self-checking testbench of the Lee wave maze router: stream driver, monitor and path predictor.
`timescale 1ns / 1ps
module tb_lee_wave_maze_router_unit;

    typedef struct {
        logic       cmd;
        logic [2:0] row;
        logic [2:0] col;
        logic       wall;
        logic [2:0] trow;
        logic [2:0] tcol;
        bit         drain;
    } maze_item_t;

    typedef struct {
        logic [2:0] row;
        logic [2:0] col;
        logic       found;
        logic       last;
    } path_cell_t;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int LONG_HOLD      = 600;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    maze_item_t pending_q[$];
    maze_item_t cur_item;
    path_cell_t path_q[$];
    logic       blocked[lwmr_pkg::CELLS];
    int         dist_of[lwmr_pkg::CELLS];
    int         errors = 0;
    int         results_seen = 0;
    int         send_gap = 0;
    int         recv_gap = 0;
    bit         long_hold_done = 1'b0;
    int         idle_cycles = 0;

    lee_wave_maze_router_unit dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report(input string what);
        $display("mismatch: %s at %0t", what, $time);
        errors++;
    endtask

    function automatic bit on_grid(input int r, input int c);
        return r >= 0 && r < lwmr_pkg::GRID_ROWS && c >= 0 && c < lwmr_pkg::GRID_COLS;
    endfunction

    // Spreads the distance wave from the start and queues the traced path, or a not-found cell.
    task automatic route_path(input int sr, input int sc, input int fr, input int fc);
        int dr[4] = '{1, -1, 0, 0};
        int dc[4] = '{0, 0, 1, -1};
        int scell, fcell, lvl, r, c, d, nr, nc, ncell, lab, n;
        bit reached, grown, ok, moved;
        path_cell_t trace[$];
        path_cell_t pc;
        for (int i = 0; i < lwmr_pkg::CELLS; i++) dist_of[i] = 127;
        scell = sr * lwmr_pkg::GRID_COLS + sc;
        fcell = fr * lwmr_pkg::GRID_COLS + fc;
        ok = !(blocked[scell] || blocked[fcell] || scell == fcell);
        reached = 1'b0;
        if (ok) begin
            dist_of[scell] = 0;
            for (lvl = 0; lvl < 126 && !reached && ok; lvl++) begin
                grown = 1'b0;
                for (r = 0; r < lwmr_pkg::GRID_ROWS && !reached; r++) begin
                    for (c = 0; c < lwmr_pkg::GRID_COLS && !reached; c++) begin
                        if (dist_of[r * lwmr_pkg::GRID_COLS + c] != lvl) continue;
                        for (d = 0; d < 4; d++) begin
                            nr = r + dr[d];
                            nc = c + dc[d];
                            if (!on_grid(nr, nc)) continue;
                            ncell = nr * lwmr_pkg::GRID_COLS + nc;
                            if (ncell == fcell) begin
                                dist_of[ncell] = lvl + 1;
                                reached = 1'b1;
                                break;
                            end
                            if (!blocked[ncell] && dist_of[ncell] == 127) begin
                                dist_of[ncell] = lvl + 1;
                                grown = 1'b1;
                            end
                        end
                    end
                end
                if (!reached && !grown) ok = 1'b0;
            end
        end
        if (!reached) begin
            pc = '{3'd0, 3'd0, 1'b0, 1'b1};
            path_q.push_back(pc);
        end else begin
            lab = dist_of[fcell];
            r = fr;
            c = fc;
            n = 1;
            pc = '{r[2:0], c[2:0], 1'b1, lab == 0};
            trace.push_back(pc);
            while (lab > 0 && n < lwmr_pkg::CELLS) begin
                moved = 1'b0;
                for (d = 0; d < 4; d++) begin
                    nr = r + dr[d];
                    nc = c + dc[d];
                    if (on_grid(nr, nc)
                        && dist_of[nr * lwmr_pkg::GRID_COLS + nc] == lab - 1) begin
                        r = nr;
                        c = nc;
                        moved = 1'b1;
                        break;
                    end
                end
                if (!moved) break;
                lab--;
                pc = '{r[2:0], c[2:0], 1'b1, lab == 0};
                trace.push_back(pc);
                n++;
            end
            trace[trace.size() - 1].last = 1'b1;
            foreach (trace[i]) path_q.push_back(trace[i]);
        end
    endtask

    task automatic apply_item(input maze_item_t it);
        if (it.cmd == lwmr_pkg::CMD_WRITE) blocked[it.row * lwmr_pkg::GRID_COLS + it.col] = it.wall;
        else route_path(it.row, it.col, it.trow, it.tcol);
    endtask

    always @(posedge aclk) begin
        logic       nv;
        maze_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            nv = s_tvalid;
            if (s_tvalid && s_tready) begin
                apply_item(cur_item);
                nv = 1'b0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_q.size() > 0) begin
                    if (pending_q.size() > 20 && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(1, 16);
                    end else if (!(pending_q[0].drain && path_q.size() != 0)) begin
                        it = pending_q.pop_front();
                        cur_item = it;
                        s_tdata <= {2'b00, it.tcol, it.trow, it.wall, it.col, it.row, it.cmd};
                        nv = 1'b1;
                    end
                end
            end
            s_tvalid <= nv;
        end
    end

    always @(posedge aclk) begin
        path_cell_t exp_cell;
        logic       nr;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (path_q.size() == 0) begin
                    report("result with no expected path cell");
                end else begin
                    exp_cell = path_q.pop_front();
                    if (m_tdata[2:0] != exp_cell.row) report("path_row");
                    if (m_tdata[5:3] != exp_cell.col) report("path_col");
                    if (m_tdata[6] != exp_cell.found) report("found");
                    if (m_tlast != exp_cell.last) report("last");
                end
            end
            if (!long_hold_done && results_seen >= 10) begin
                long_hold_done = 1'b1;
                recv_gap = LONG_HOLD;
            end
            if (recv_gap > 0) begin
                recv_gap--;
                nr = 1'b0;
            end else if (pending_q.size() > 20 && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(1, 16);
                nr = 1'b0;
            end else begin
                nr = 1'b1;
            end
            m_tready <= nr;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic maze_item_t wr_cell(input int r, input int c, input bit w);
        maze_item_t it;
        it = '{lwmr_pkg::CMD_WRITE, r[2:0], c[2:0], w, 3'($urandom), 3'($urandom), 1'b0};
        return it;
    endfunction

    function automatic maze_item_t solve_cmd(input int sr, input int sc,
                                             input int fr, input int fc);
        maze_item_t it;
        it = '{lwmr_pkg::CMD_SOLVE, sr[2:0], sc[2:0], 1'($urandom), fr[2:0], fc[2:0], 1'b0};
        return it;
    endfunction

    initial begin
        maze_item_t it;
        int n_walls;
        for (int i = 0; i < lwmr_pkg::CELLS; i++) blocked[i] = 1'b0;
        // Directed part: open corner to corner, degenerate solves, walled ends, sealed finish, detour.
        pending_q.push_back(solve_cmd(0, 0, 7, 7));
        pending_q.push_back(solve_cmd(7, 7, 0, 0));
        pending_q.push_back(solve_cmd(3, 4, 3, 4));
        pending_q.push_back(solve_cmd(0, 7, 0, 6));
        pending_q.push_back(wr_cell(0, 0, 1'b1));
        pending_q.push_back(solve_cmd(0, 0, 5, 5));
        pending_q.push_back(solve_cmd(5, 5, 0, 0));
        pending_q.push_back(wr_cell(0, 0, 1'b0));
        pending_q.push_back(wr_cell(6, 7, 1'b1));
        pending_q.push_back(wr_cell(7, 6, 1'b1));
        pending_q.push_back(solve_cmd(0, 0, 7, 7));
        pending_q.push_back(wr_cell(6, 7, 1'b0));
        pending_q.push_back(wr_cell(7, 6, 1'b0));
        for (int r = 0; r < 7; r++) pending_q.push_back(wr_cell(r, 3, 1'b1));
        it = solve_cmd(0, 0, 0, 7);
        it.drain = 1'b1;
        pending_q.push_back(it);
        for (int r = 0; r < 7; r++) pending_q.push_back(wr_cell(r, 3, 1'b0));
        // Random part: short runs of map writes each followed by a solve.
        while (pending_q.size() < 140) begin
            n_walls = $urandom_range(0, 5);
            repeat (n_walls) begin
                pending_q.push_back(wr_cell($urandom_range(0, 7), $urandom_range(0, 7),
                                            $urandom_range(0, 2) == 0));
            end
            if ($urandom_range(0, 9) == 0) begin
                it = solve_cmd($urandom_range(0, 7), $urandom_range(0, 7),
                               $urandom_range(0, 7), $urandom_range(0, 7));
            end else begin
                it = solve_cmd($urandom_range(0, 3), $urandom_range(0, 7),
                               $urandom_range(3, 7), $urandom_range(0, 7));
            end
            it.drain = ($urandom_range(0, 19) == 0);
            pending_q.push_back(it);
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_q.size() == 0 && !s_tvalid && path_q.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && path_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
